// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge, reset held off
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check a next-cycle implication on every rising clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/cia_pkg.sv =====
package cia_pkg;

  typedef enum logic [1:0] {
    FUNC_ADVANCE = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_WRITE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_HOLD = 2'd2
  } state_e;

  // Register indexes with special behaviour
  localparam logic [3:0] REG_PRB  = 4'h1;
  localparam logic [3:0] REG_TALO = 4'h4;
  localparam logic [3:0] REG_TAHI = 4'h5;
  localparam logic [3:0] REG_TBLO = 4'h6;
  localparam logic [3:0] REG_TBHI = 4'h7;
  localparam logic [3:0] REG_TOD0 = 4'h8;
  localparam logic [3:0] REG_TOD1 = 4'h9;
  localparam logic [3:0] REG_TOD2 = 4'ha;
  localparam logic [3:0] REG_TOD3 = 4'hb;
  localparam logic [3:0] REG_SDR  = 4'hc;
  localparam logic [3:0] REG_ICR  = 4'hd;
  localparam logic [3:0] REG_CRA  = 4'he;
  localparam logic [3:0] REG_CRB  = 4'hf;

  localparam int unsigned FIRST_UNIT_DEFAULT = 1;

  // Controller to datapath
  typedef struct packed {
    logic exec;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } stat_t;

endpackage

// ===== src/cia_timers_tod_interrupts.sv =====
// Channel  Handshake            Payload
// in       in_valid_i/ready_o   func_i reg_index_i write_data_i delta_cycles_i
// out      out_valid_o/ready_i  read_data_o irq_line_o timer_port_bits_o
// Each item is accepted, executed in the datapath, then presented.
// The controller sequences one item at a time; the next accept follows the
// output transfer. Reset is asynchronous and loads the port register values
// set by FIRST_UNIT. A stalled output holds the result and blocks input.
module cia_timers_tod_interrupts #(
  parameter int unsigned FIRST_UNIT = cia_pkg::FIRST_UNIT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [3:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] delta_cycles_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_line_o,
  output logic [1:0] timer_port_bits_o
);
  import cia_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the items
  cia_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  // Hold the unit state and execute
  cia_dp #(.FIRST_UNIT(FIRST_UNIT)) u_dp (
    .clk_i, .rst_ni, .load_i(in_valid_i && in_ready_o),
    .func_i, .reg_index_i, .write_data_i, .delta_cycles_i,
    .cmd_i(cmd), .stat_o(stat),
    .read_data_o, .irq_line_o, .timer_port_bits_o
  );
endmodule

// ===== src/cia_ctrl.sv =====
module cia_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cia_pkg::stat_t stat_i,
  output cia_pkg::cmd_t  cmd_o
);
  import cia_pkg::*;

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Accept, execute, then present the result until transferred
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== src/cia_dp.sv =====
module cia_dp #(
  parameter int unsigned FIRST_UNIT = cia_pkg::FIRST_UNIT_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic [1:0]     func_i,
  input  logic [3:0]     reg_index_i,
  input  logic [7:0]     write_data_i,
  input  logic [7:0]     delta_cycles_i,
  input  cia_pkg::cmd_t  cmd_i,
  output cia_pkg::stat_t stat_o,
  output logic [7:0]     read_data_o,
  output logic           irq_line_o,
  output logic [1:0]     timer_port_bits_o
);
  import cia_pkg::*;

  localparam logic [7:0] PRA_RST = (FIRST_UNIT != 0) ? 8'd127 : 8'd151;
  localparam logic [7:0] DDRA_RST = (FIRST_UNIT != 0) ? 8'd255 : 8'd63;

  // Captured item
  logic [1:0] func_q;
  logic [3:0] idx_q;
  logic [7:0] wd_q, dt_q;

  logic [7:0]  rf_q [16];
  logic [7:0]  rf_d [16];
  logic [15:0] ta_q, ta_d, tb_q, tb_d, la_q, la_d, lb_q, lb_d;
  logic [7:0]  ifr_q, ifr_d, rd_q, rd_d;
  logic        aup_q, aup_d, run_q, run_d, frz_q, frz_d, alm_q, alm_d;
  logic [3:0]  sl_q, sl_d, sq_q, sq_d;
  logic [7:0]  lt_q [4];
  logic [7:0]  lt_d [4];
  logic [7:0]  at_q [4];
  logic [7:0]  at_d [4];

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      func_q <= func_i;
      idx_q  <= reg_index_i;
      wd_q   <= write_data_i;
      dt_q   <= delta_cycles_i;
    end
  end

  // Hold the unit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 3; i < 16; i++) rf_q[i] <= 8'd0;
      rf_q[0] <= PRA_RST;
      rf_q[1] <= 8'd255;
      rf_q[2] <= DDRA_RST;
      ta_q <= '0; tb_q <= '0; la_q <= '0; lb_q <= '0;
      ifr_q <= '0; rd_q <= '0;
      aup_q <= 1'b0; run_q <= 1'b0; frz_q <= 1'b0; alm_q <= 1'b0;
      sl_q <= '0; sq_q <= '0;
      for (int i = 0; i < 4; i++) begin
        lt_q[i] <= '0;
        at_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      rf_q <= rf_d;
      ta_q <= ta_d; tb_q <= tb_d; la_q <= la_d; lb_q <= lb_d;
      ifr_q <= ifr_d; rd_q <= rd_d;
      aup_q <= aup_d; run_q <= run_d; frz_q <= frz_d; alm_q <= alm_d;
      sl_q <= sl_d; sq_q <= sq_d;
      lt_q <= lt_d; at_q <= at_d;
    end
  end

  // Work out the operation in one step
  always_comb begin
    logic [7:0] cr, t, one, ten, mo, mt, ho;
    logic       ht, pm, bdec, bz;
    logic [1:0] mode;
    rf_d = rf_q; ta_d = ta_q; tb_d = tb_q; la_d = la_q; lb_d = lb_q;
    ifr_d = ifr_q; rd_d = 8'd0;
    aup_d = aup_q; run_d = run_q; frz_d = frz_q; alm_d = alm_q;
    sl_d = sl_q; sq_d = sq_q; lt_d = lt_q; at_d = at_q;
    cr = '0; t = '0; one = '0; ten = '0; mo = '0; mt = '0; ho = '0;
    ht = 1'b0; pm = 1'b0; bdec = 1'b0; bz = 1'b0; mode = '0;
    case (func_e'(func_q))
      FUNC_ADVANCE: begin
        // Timer A
        cr = rf_d[REG_CRA];
        if (cr[0] && !cr[5]) begin
          ta_d = (ta_q > {8'd0, dt_q}) ? ta_q - {8'd0, dt_q} : 16'd0;
          if (ta_d == 16'd0) begin
            aup_d = 1'b1;
            if (cr[1] && !cr[2]) rf_d[REG_PRB][6] = ~rf_d[REG_PRB][6];
            if (!cr[3]) ta_d = la_q;
            else rf_d[REG_CRA][0] = 1'b0;
            ifr_d[0] = 1'b1;
            if (rf_d[REG_ICR][0]) ifr_d[7] = 1'b1;
            if (rf_d[REG_CRA][6] && sl_d != 4'd0) begin
              sl_d = sl_d - 4'd1;
              if (sl_d == 4'd0) begin
                ifr_d[3] = 1'b1;
                if (rf_d[REG_ICR][3]) ifr_d[7] = 1'b1;
                if (sq_d != 4'd0) begin
                  sl_d = sq_d;
                  sq_d = 4'd0;
                end
              end
            end
          end
        end
        // Timer B
        cr = rf_d[REG_CRB];
        mode = cr[6:5];
        if (cr[0]) begin
          if (mode == 2'b00) begin
            tb_d = (tb_q > {8'd0, dt_q}) ? tb_q - {8'd0, dt_q} : 16'd0;
            bdec = 1'b1;
          end else if (mode == 2'b10) begin
            bdec = 1'b1;
            if (aup_d) begin
              aup_d = 1'b0;
              if (tb_d != 16'd0) tb_d = tb_d - 16'd1;
            end
          end
          bz = bdec && (tb_d == 16'd0);
          if (bz) begin
            if (cr[1] && !cr[2]) rf_d[REG_PRB][7] = ~rf_d[REG_PRB][7];
            if (!cr[3]) tb_d = lb_q;
            else rf_d[REG_CRB][0] = 1'b0;
            ifr_d[1] = 1'b1;
            if (rf_d[REG_ICR][1]) ifr_d[7] = 1'b1;
          end
        end
        if (alm_q) begin
          alm_d = 1'b0;
          ifr_d[2] = 1'b1;
          if (rf_d[REG_ICR][2]) ifr_d[7] = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (run_q) begin
          t = lt_q[0] + 8'd1;
          if (t > 8'd9) begin
            one = {4'd0, lt_q[1][3:0]} + 8'd1;
            ten = {4'd0, lt_q[1][7:4]};
            t = 8'd0;
            if (one > 8'd9) begin
              one = 8'd0;
              ten = ten + 8'd1;
              if (ten > 8'd5) begin
                mo = {4'd0, lt_q[2][3:0]} + 8'd1;
                mt = {4'd0, lt_q[2][7:4]};
                ten = 8'd0;
                if (mo > 8'd9) begin
                  mo = 8'd0;
                  mt = mt + 8'd1;
                  if (mt > 8'd5) begin
                    ho = {4'd0, lt_q[3][3:0]} + 8'd1;
                    ht = lt_q[3][4];
                    pm = lt_q[3][7];
                    mt = 8'd0;
                    if ((!ht && ho > 8'd9) || (ht && ho > 8'd1)) begin
                      ho = 8'd0;
                      if (ht) pm = ~pm;
                      ht = ~ht;
                    end
                    lt_d[3] = {pm, 2'b00, ht, ho[3:0]};
                  end
                end
                lt_d[2] = {mt[3:0], mo[3:0]};
              end
            end
            lt_d[1] = {ten[3:0], one[3:0]};
          end
          lt_d[0] = t;
          if (lt_d[0] == at_q[0] && lt_d[1] == at_q[1] &&
              lt_d[2] == at_q[2] && lt_d[3] == at_q[3]) alm_d = 1'b1;
        end
      end
      FUNC_READ: begin
        case (idx_q)
          REG_TALO: rd_d = ta_q[7:0];
          REG_TAHI: rd_d = ta_q[15:8];
          REG_TBLO: rd_d = tb_q[7:0];
          REG_TBHI: rd_d = tb_q[15:8];
          REG_TOD0: begin
            rd_d  = frz_q ? rf_q[REG_TOD0] : lt_q[0];
            frz_d = 1'b0;
          end
          REG_TOD1: rd_d = frz_q ? rf_q[REG_TOD1] : lt_q[1];
          REG_TOD2: rd_d = frz_q ? rf_q[REG_TOD2] : lt_q[2];
          REG_TOD3: begin
            frz_d = 1'b1;
            rf_d[REG_TOD0] = lt_q[0];
            rf_d[REG_TOD1] = lt_q[1];
            rf_d[REG_TOD2] = lt_q[2];
            rf_d[REG_TOD3] = lt_q[3];
            rd_d = lt_q[3];
          end
          REG_ICR: begin
            rd_d  = ifr_q;
            ifr_d = 8'd0;
          end
          default: rd_d = rf_q[idx_q];
        endcase
      end
      FUNC_WRITE: begin
        case (idx_q)
          REG_TALO: la_d[7:0] = wd_q;
          REG_TAHI: begin
            la_d[15:8] = wd_q;
            if (!rf_q[REG_CRA][0]) ta_d = {wd_q, la_q[7:0]};
          end
          REG_TBLO: lb_d[7:0] = wd_q;
          REG_TBHI: begin
            lb_d[15:8] = wd_q;
            if (!rf_q[REG_CRB][0]) tb_d = {wd_q, lb_q[7:0]};
          end
          REG_TOD0: begin
            if (rf_q[REG_CRB][7]) at_d[0] = wd_q;
            else begin
              rf_d[REG_TOD0] = wd_q;
              lt_d[0] = wd_q;
              lt_d[1] = rf_q[REG_TOD1];
              lt_d[2] = rf_q[REG_TOD2];
              lt_d[3] = rf_q[REG_TOD3];
            end
            run_d = 1'b1;
          end
          REG_TOD1, REG_TOD2, REG_TOD3: begin
            if (idx_q == REG_TOD3) run_d = 1'b0;
            if (rf_q[REG_CRB][7]) at_d[idx_q[1:0]] = wd_q;
            else rf_d[idx_q] = wd_q;
          end
          REG_SDR: begin
            if (sl_q == 4'd0) sl_d = 4'd8;
            else sq_d = 4'd8;
            rf_d[REG_SDR] = wd_q;
          end
          REG_ICR: begin
            if (wd_q[7]) rf_d[REG_ICR] = rf_q[REG_ICR] | wd_q;
            else rf_d[REG_ICR] = rf_q[REG_ICR] & ~(wd_q | 8'h80);
          end
          REG_CRA: begin
            rf_d[REG_CRA] = wd_q & 8'hef;
            if (wd_q[4]) ta_d = la_q;
          end
          REG_CRB: begin
            rf_d[REG_CRB] = wd_q & 8'hef;
            if (wd_q[4]) tb_d = lb_q;
          end
          default: rf_d[idx_q] = wd_q;
        endcase
      end
      default: ;
    endcase
  end

  assign stat_o.done       = cmd_i.exec;
  assign read_data_o       = rd_q;
  assign irq_line_o        = ifr_q[7];
  assign timer_port_bits_o = rf_q[REG_PRB][7:6];
endmodule

// ===== src/cia_checker.sv =====
`include "assert_macros.svh"
module cia_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic [1:0] func_i
);
  import cia_pkg::*;

  // Only one item in flight
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready during output")
  // Accept leads to no output next cycle
  `ASSERT_NEXT(a_acc, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o && !in_ready_o,
    "accept not followed by execute")
  // Stalled output holds data
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(read_data_o), "stalled output changed")
  // Non-read yields zero data
  `ASSERT_NEXT(a_zero, clk_i, rst_ni, in_valid_i && in_ready_o && func_i != FUNC_READ,
    ##1 (read_data_o == 8'd0), "non-read data not zero")
endmodule

bind cia_timers_tod_interrupts cia_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .read_data_o, .func_i
);

// ===== tb/cia_timers_tod_interrupts_tb.sv =====
`timescale 1ns / 100ps

module cia_timers_tod_interrupts_tb;
  import cia_pkg::*;

  localparam int unsigned NUM_RANDOM = 750;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [1:0] port_bits;
  } cia_result_t;

  // Predicts the adapter and holds the expected results in order
  class cia_scoreboard;
    logic [7:0]  regs [16];
    logic [15:0] ta_count, tb_count, ta_latch, tb_latch;
    logic [7:0]  icr_flags;
    bit          ta_pending;
    logic [3:0]  sr_left, sr_queued;
    bit          tod_running, tod_frozen, alarm_hit;
    logic [7:0]  tod_live [4];
    logic [7:0]  tod_alarm [4];
    cia_result_t expected_q [$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[0] = 8'd127;
      regs[1] = 8'd255;
      regs[2] = 8'd255;
      ta_count = '0; tb_count = '0; ta_latch = '0; tb_latch = '0;
      icr_flags = '0;
      ta_pending = 0;
      sr_left = '0; sr_queued = '0;
      tod_running = 0; tod_frozen = 0; alarm_hit = 0;
      foreach (tod_live[i]) begin
        tod_live[i] = '0;
        tod_alarm[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void raise_flag(logic [7:0] bit_mask);
      icr_flags |= bit_mask;
      if ((regs[REG_ICR] & bit_mask) != 0) icr_flags |= 8'h80;
    endfunction

    function void step_timer_a(logic [7:0] dt);
      logic [7:0] cr;
      cr = regs[REG_CRA];
      if (!cr[0] || cr[5]) return;
      ta_count = (ta_count > dt) ? ta_count - dt : 16'd0;
      if (ta_count != 0) return;
      ta_pending = 1;
      if (cr[1] && !cr[2]) regs[REG_PRB] ^= 8'h40;
      if (!cr[3]) ta_count = ta_latch;
      else regs[REG_CRA][0] = 1'b0;
      raise_flag(8'h01);
      if (regs[REG_CRA][6] && sr_left != 0) begin
        sr_left--;
        if (sr_left == 0) begin
          raise_flag(8'h08);
          if (sr_queued != 0) begin
            sr_left = sr_queued;
            sr_queued = 0;
          end
        end
      end
    endfunction

    function void step_timer_b(logic [7:0] dt);
      logic [7:0] cr;
      cr = regs[REG_CRB];
      if (!cr[0]) return;
      if (cr[6:5] == 2'b00) begin
        tb_count = (tb_count > dt) ? tb_count - dt : 16'd0;
      end else if (cr[6:5] == 2'b10) begin
        if (ta_pending) begin
          ta_pending = 0;
          if (tb_count != 0) tb_count--;
        end
      end else begin
        return;
      end
      if (tb_count != 0) return;
      if (cr[1] && !cr[2]) regs[REG_PRB] ^= 8'h80;
      if (!cr[3]) tb_count = tb_latch;
      else regs[REG_CRB][0] = 1'b0;
      raise_flag(8'h02);
    endfunction

    function void step_tod();
      logic [7:0] t, one, ten, mo, mt, h, ho, ht;
      bit pm;
      if (!tod_running) return;
      t = tod_live[0] + 8'd1;
      if (t > 9) begin
        one = {4'd0, tod_live[1][3:0]} + 8'd1;
        ten = {4'd0, tod_live[1][7:4]};
        t = 0;
        if (one > 9) begin
          one = 0;
          ten++;
          if (ten > 5) begin
            mo = {4'd0, tod_live[2][3:0]} + 8'd1;
            mt = {4'd0, tod_live[2][7:4]};
            ten = 0;
            if (mo > 9) begin
              mo = 0;
              mt++;
              if (mt > 5) begin
                h = tod_live[3];
                ho = {4'd0, h[3:0]} + 8'd1;
                ht = {7'd0, h[4]};
                pm = h[7];
                mt = 0;
                if ((ht == 0 && ho > 9) || (ht != 0 && ho > 1)) begin
                  ho = 0;
                  ht++;
                  if (ht > 1) begin
                    ht = 0;
                    pm = !pm;
                  end
                end
                tod_live[3] = {pm, 2'b00, ht[0], ho[3:0]};
              end
            end
            tod_live[2] = {mt[3:0], mo[3:0]};
          end
        end
        tod_live[1] = {ten[3:0], one[3:0]};
      end
      tod_live[0] = t;
      if (tod_live == tod_alarm) alarm_hit = 1;
    endfunction

    function logic [7:0] bus_read(logic [3:0] idx);
      logic [7:0] v;
      case (idx)
        REG_TALO: v = ta_count[7:0];
        REG_TAHI: v = ta_count[15:8];
        REG_TBLO: v = tb_count[7:0];
        REG_TBHI: v = tb_count[15:8];
        REG_TOD0: begin
          v = tod_frozen ? regs[8] : tod_live[0];
          tod_frozen = 0;
        end
        REG_TOD1, REG_TOD2: v = tod_frozen ? regs[idx] : tod_live[idx - 8];
        REG_TOD3: begin
          tod_frozen = 1;
          for (int i = 0; i < 4; i++) regs[8 + i] = tod_live[i];
          v = regs[REG_TOD3];
        end
        REG_ICR: begin
          v = icr_flags;
          icr_flags = 0;
        end
        default: v = regs[idx];
      endcase
      return v;
    endfunction

    function void bus_write(logic [3:0] idx, logic [7:0] v);
      bit alarm_sel;
      alarm_sel = regs[REG_CRB][7];
      case (idx)
        REG_TALO: ta_latch[7:0] = v;
        REG_TAHI: begin
          ta_latch[15:8] = v;
          if (!regs[REG_CRA][0]) ta_count = ta_latch;
        end
        REG_TBLO: tb_latch[7:0] = v;
        REG_TBHI: begin
          tb_latch[15:8] = v;
          if (!regs[REG_CRB][0]) tb_count = tb_latch;
        end
        REG_TOD0: begin
          if (alarm_sel) tod_alarm[0] = v;
          else begin
            regs[8] = v;
            for (int i = 0; i < 4; i++) tod_live[i] = regs[8 + i];
          end
          tod_running = 1;
        end
        REG_TOD1, REG_TOD2, REG_TOD3: begin
          if (idx == REG_TOD3) tod_running = 0;
          if (alarm_sel) tod_alarm[idx - 8] = v;
          else regs[idx] = v;
        end
        REG_SDR: begin
          if (sr_left == 0) sr_left = 8;
          else sr_queued = 8;
          regs[REG_SDR] = v;
        end
        REG_ICR: begin
          if (v[7]) regs[REG_ICR] |= v;
          else regs[REG_ICR] &= ~(v | 8'h80);
        end
        REG_CRA: begin
          regs[REG_CRA] = v & 8'hef;
          if (v[4]) ta_count = ta_latch;
        end
        REG_CRB: begin
          regs[REG_CRB] = v & 8'hef;
          if (v[4]) tb_count = tb_latch;
        end
        default: regs[idx] = v;
      endcase
    endfunction

    // Note an accepted transfer and predict its result
    function void note_input(func_e fn, logic [3:0] idx, logic [7:0] wd, logic [7:0] dt);
      cia_result_t r;
      r.read_data = '0;
      case (fn)
        FUNC_ADVANCE: begin
          step_timer_a(dt);
          step_timer_b(dt);
          if (alarm_hit) begin
            alarm_hit = 0;
            raise_flag(8'h04);
          end
        end
        FUNC_TICK:  step_tod();
        FUNC_READ:  r.read_data = bus_read(idx);
        default:    bus_write(idx, wd);
      endcase
      r.irq_line  = icr_flags[7];
      r.port_bits = regs[REG_PRB][7:6];
      expected_q.push_back(r);
    endfunction

    // Compare an output transfer with the oldest prediction
    function void check_result(cia_result_t got);
      cia_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected rd=%h irq=%b pb=%b, got rd=%h irq=%b pb=%b",
                   exp_r.read_data, exp_r.irq_line, exp_r.port_bits,
                   got.read_data, got.irq_line, got.port_bits);
      end
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       in_valid_i, in_ready_o;
  logic [1:0] func_i;
  logic [3:0] reg_index_i;
  logic [7:0] write_data_i, delta_cycles_i;
  logic       out_valid_o, out_ready_i;
  logic [7:0] read_data_o;
  logic       irq_line_o;
  logic [1:0] timer_port_bits_o;

  cia_scoreboard sb;
  bit            idle_off;
  int unsigned   quiet_cycles;
  int unsigned   stall_left;

  cia_timers_tod_interrupts i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive one transfer, with random idling before it
  task automatic send_item(func_e fn, logic [3:0] idx, logic [7:0] wd, logic [7:0] dt);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    reg_index_i    <= idx;
    write_data_i   <= wd;
    delta_cycles_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Random item: mostly advances and writes to any register, also reads and TOD ticks
  task automatic send_random();
    int unsigned sel;
    logic [3:0] idx;
    logic [7:0] wd;
    sel = $urandom_range(0, 99);
    idx = 4'($urandom);
    wd  = 8'($urandom);
    if (idx == REG_TAHI || idx == REG_TBHI) wd = 8'($urandom_range(0, 2));
    if (sel < 35)      send_item(FUNC_ADVANCE, 4'($urandom), 8'($urandom),
                                 ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                 8'($urandom_range(0, 8)));
    else if (sel < 50) send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom));
    else if (sel < 72) send_item(FUNC_READ, idx, 8'($urandom), 8'($urandom));
    else               send_item(FUNC_WRITE, idx, wd, 8'($urandom));
  endtask

  // Record input transfers and check output transfers
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_input(func_e'(func_i), reg_index_i, write_data_i, delta_cycles_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{read_data_o, irq_line_o, timer_port_bits_o});
  end

  // Receiver stalls in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (idle_off) begin
      out_ready_i <= 1'b1;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    quiet_cycles   = 0;
    idle_off       = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_ADVANCE;
    reg_index_i    = '0;
    write_data_i   = '0;
    delta_cycles_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads after reset, timers, one-shot, force load, TOD, alarm
    for (int i = 0; i < 3; i++) send_item(FUNC_READ, 4'(i), 8'h00, 8'h00);
    send_item(FUNC_WRITE, REG_ICR, 8'h9f, 8'h00);
    send_item(FUNC_WRITE, REG_TALO, 8'h05, 8'h00);
    send_item(FUNC_WRITE, REG_TAHI, 8'h00, 8'h00);
    send_item(FUNC_WRITE, REG_TBLO, 8'h02, 8'h00);
    send_item(FUNC_WRITE, REG_TBHI, 8'h00, 8'h00);
    send_item(FUNC_WRITE, REG_CRA, 8'h53, 8'h00);
    send_item(FUNC_WRITE, REG_CRB, 8'h53, 8'h00);
    send_item(FUNC_WRITE, REG_SDR, 8'hff, 8'h00);
    send_item(FUNC_ADVANCE, 4'h0, 8'h00, 8'hff);
    send_item(FUNC_ADVANCE, 4'h0, 8'h00, 8'h00);
    send_item(FUNC_READ, REG_ICR, 8'h00, 8'h00);
    send_item(FUNC_READ, REG_CRA, 8'h00, 8'h00);
    send_item(FUNC_WRITE, REG_CRA, 8'h09, 8'h00);
    send_item(FUNC_ADVANCE, 4'h0, 8'h00, 8'h01);
    send_item(FUNC_WRITE, REG_TOD3, 8'h91, 8'h00);
    send_item(FUNC_WRITE, REG_TOD2, 8'h59, 8'h00);
    send_item(FUNC_WRITE, REG_TOD1, 8'h59, 8'h00);
    send_item(FUNC_WRITE, REG_TOD0, 8'h09, 8'h00);
    send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00);
    send_item(FUNC_READ, REG_TOD3, 8'h00, 8'h00);
    send_item(FUNC_READ, REG_TOD0, 8'h00, 8'h00);
    send_item(FUNC_WRITE, REG_CRB, 8'h80, 8'h00);
    send_item(FUNC_WRITE, REG_TOD0, 8'h01, 8'h00);
    send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00);

    // Random part; no idling in the last stretch
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 100) idle_off = 1;
      send_random();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== cia_timers_tod_interrupts.f =====
+incdir+src
src/cia_pkg.sv
src/cia_ctrl.sv
src/cia_dp.sv
src/cia_timers_tod_interrupts.sv
src/cia_checker.sv
tb/cia_timers_tod_interrupts_tb.sv
